// ===== src/lxrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagged XOR generator package
// Shared constants and the command and status types that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lxrg_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd67397;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd7364893;

  localparam logic [ADDR_W-1:0] LAG_A = 8'd24;
  localparam logic [ADDR_W-1:0] LAG_B = 8'd55;
  localparam logic [ADDR_W-1:0] LAG_C = 8'd61;

  typedef struct packed {
    logic load_seed;
    logic seed_step;
    logic read_lags;
    logic read_third;
    logic write_draw;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_full;
  } status_t;

endpackage

// ===== src/lagged_xor_random_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagged XOR random generator
// Parisi-Rapuano generator with a 256-word lag table, returning one raw
// 32-bit word for each draw transaction.
// ----------------------------------------------------------------------------
// A seed transaction (mode 0) fills the 256-entry table from a congruential
// sequence, one entry per cycle, and the block accepts its next transaction
// once the last entry is written; it returns no word. A draw transaction
// (mode 1) runs through the acceptance cycle, a read of the two sum lags
// on both table ports, a read of the XOR lag while the sum is formed, and the
// write back of the sum together with loading the output register. The
// output register lets the next draw start while a word still waits; the
// write back holds while that word is stalled. The table is not cleared at
// reset; a seed must precede the first draw.
module lagged_xor_random_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               mode,
  input  logic signed [lxrg_pkg::WORD_W-1:0] seed_value,
  output logic                               word_valid,
  input  logic                               word_stall,
  output logic        [lxrg_pkg::WORD_W-1:0] random_word
);

  lxrg_pkg::cmd_t    cmd;
  lxrg_pkg::status_t status;

  lxrg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (mode),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lxrg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .seed_value  (seed_value),
    .random_word (random_word),
    .word_valid  (word_valid),
    .word_stall  (word_stall)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_seed, cmd.seed_step, cmd.read_lags, cmd.read_third, cmd.write_draw}))
    else $error("More than one datapath command is active.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.write_draw |-> !(word_valid && word_stall))
    else $error("A draw overwrote a word that was still waiting.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(word_valid) |-> $past(cmd.write_draw))
    else $error("A word appeared without a draw.");

  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && !mode) |=> !word_valid || $past(word_valid))
    else $error("A seed transaction produced a word.");
`endif

endmodule

// ===== src/lxrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagged XOR generator controller
// Sequences the seeding sweep and the three-step draw, and drives the input
// stall.
// ----------------------------------------------------------------------------
module lxrg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             mode,
  output logic             item_stall,
  input  lxrg_pkg::status_t status,
  output lxrg_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SEED,
    READ_LAGS,
    READ_THIRD,
    WRITE_DRAW
  } state_t;

  state_t state;
  logic   accept;

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd            = '0;
    cmd.load_seed  = accept && !mode;
    cmd.seed_step  = (state == SEED);
    cmd.read_lags  = (state == READ_LAGS);
    cmd.read_third = (state == READ_THIRD);
    cmd.write_draw = (state == WRITE_DRAW) && !status.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= mode ? READ_LAGS : SEED;
          end
        end
        SEED: begin
          if (status.seed_last) begin
            state <= IDLE;
          end
        end
        READ_LAGS: begin
          state <= READ_THIRD;
        end
        READ_THIRD: begin
          state <= WRITE_DRAW;
        end
        WRITE_DRAW: begin
          if (!status.out_full) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lxrg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lagged XOR generator datapath
// Holds the lag table memory, the table pointer, the congruential seed
// register, the lag sum and the output register.
// ----------------------------------------------------------------------------
module lxrg_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lxrg_pkg::cmd_t                      cmd,
  output lxrg_pkg::status_t                   status,
  input  logic signed [lxrg_pkg::WORD_W-1:0]  seed_value,
  output logic        [lxrg_pkg::WORD_W-1:0]  random_word,
  output logic                                word_valid,
  input  logic                                word_stall
);

  logic [lxrg_pkg::WORD_W-1:0] lag_table [lxrg_pkg::TABLE_DEPTH];

  logic [lxrg_pkg::ADDR_W-1:0] table_pointer;
  logic [lxrg_pkg::ADDR_W-1:0] seed_count;
  logic [lxrg_pkg::WORD_W-1:0] lcg_state;
  logic [lxrg_pkg::WORD_W-1:0] lcg_next;
  logic [lxrg_pkg::WORD_W-1:0] lag_sum;
  logic [lxrg_pkg::WORD_W-1:0] read_a;
  logic [lxrg_pkg::WORD_W-1:0] read_b;
  logic [lxrg_pkg::ADDR_W-1:0] addr_a;
  logic [lxrg_pkg::ADDR_W-1:0] addr_b;
  logic [lxrg_pkg::ADDR_W-1:0] write_addr;
  logic [lxrg_pkg::WORD_W-1:0] write_data;
  logic                        write_en;

  assign lcg_next = lcg_state * lxrg_pkg::LCG_MUL + lxrg_pkg::LCG_ADD;

  assign addr_a = cmd.read_third ? (table_pointer - lxrg_pkg::LAG_C)
                                 : (table_pointer - lxrg_pkg::LAG_A);
  assign addr_b = table_pointer - lxrg_pkg::LAG_B;

  assign write_en   = cmd.seed_step || cmd.write_draw;
  assign write_addr = cmd.seed_step ? seed_count : table_pointer;
  assign write_data = cmd.seed_step ? lcg_next : lag_sum;

  assign status.seed_last = &seed_count;
  assign status.out_full  = word_valid && word_stall;

  always_ff @(posedge clk) begin
    if (write_en) begin
      lag_table[write_addr] <= write_data;
    end
    if (cmd.read_lags || cmd.read_third) begin
      read_a <= lag_table[addr_a];
    end
    if (cmd.read_lags) begin
      read_b <= lag_table[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      lcg_state <= unsigned'(seed_value);
    end else if (cmd.seed_step) begin
      lcg_state <= lcg_next;
    end
    if (cmd.read_third) begin
      lag_sum <= read_a + read_b;
    end
    if (cmd.write_draw) begin
      random_word <= lag_sum ^ read_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_pointer <= '0;
      seed_count    <= '0;
      word_valid    <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        table_pointer <= '0;
        seed_count    <= '0;
      end else if (cmd.seed_step) begin
        seed_count <= seed_count + 1'b1;
      end else if (cmd.write_draw) begin
        table_pointer <= table_pointer + 1'b1;
      end
      if (cmd.write_draw) begin
        word_valid <= 1'b1;
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end
    end
  end

endmodule
